/* rtl/bra_pkg.sv */
// Shared types and constants for the bandwidth request aggregator.
// No dependencies; imported by every other file of the block.
package bra_pkg;

  localparam int MAX_USERS  = 32;
  localparam int ID_BITS    = 16;
  localparam int LEVEL_BITS = 24;

  // Only the low bits of each input field take part.
  localparam int KEY_W = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int LVL_W = (LEVEL_BITS < 24) ? LEVEL_BITS : 24;
  localparam int CNT_W = $clog2(MAX_USERS + 1);
  localparam int SUM_W = LVL_W + CNT_W;

  localparam logic [28:0] TOTAL_MAX = 29'h1FFF_FFFF;
  localparam logic [5:0]  COUNT_MAX = 6'd63;
  localparam logic [7:0]  HZ_SCALE  = 8'd250;   // 1000 / 4

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] device_id;
    logic [23:0] level;
  } bra_req_t;

  typedef struct packed {
    logic [28:0] total_kib;
    logic [36:0] total_hz;
    logic [2:0]  status;
    logic [5:0]  user_count;
  } bra_rsp_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             act;
    logic             hit;
    logic [LVL_W-1:0] hit_level;
    logic             free;
  } bra_tok_t;

  // Commit broadcast once the token has left the last cell.
  typedef struct packed {
    logic             en;
    logic             hit;
    logic             mode;
    logic [LVL_W-1:0] level;
  } bra_cmt_t;

endpackage

/* rtl/bra_cell.sv */
// One table entry of the aggregator: key, level, valid, plus the search stage.
// Depends on bra_pkg.
module bra_cell import bra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [KEY_W-1:0] skey,
  input  bra_tok_t         tok_in,
  output bra_tok_t         tok_out,
  input  bra_cmt_t         cmt
);

  logic [KEY_W-1:0] key;
  logic [LVL_W-1:0] level;
  logic             valid;
  logic             hit_here;
  logic             free_here;
  logic             match;

  assign match = valid && (key == skey);

  always_ff @(posedge clk) begin
    tok_out.hit       <= tok_in.hit | match;
    tok_out.hit_level <= match ? level : tok_in.hit_level;
    tok_out.free      <= tok_in.free | !valid;
    if (rst) begin
      valid      <= 1'b0;
      tok_out.act <= 1'b0;
    end else begin
      tok_out.act <= tok_in.act;
      if (cmt.en) begin
        if (cmt.hit && hit_here) begin
          if (cmt.mode == MODE_REMOVE) begin
            valid <= 1'b0;
          end
        end else if (!cmt.hit && free_here && cmt.mode == MODE_ADD) begin
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.act) begin
      hit_here  <= match;
      // first free entry only: no earlier cell was free
      free_here <= !valid && !tok_in.free;
    end
    if (cmt.en && cmt.mode == MODE_ADD) begin
      if (cmt.hit && hit_here) begin
        level <= cmt.level;
      end else if (!cmt.hit && free_here) begin
        key   <= skey;
        level <= cmt.level;
      end
    end
  end

endmodule

/* rtl/bandwidth_request_aggregator.sv */
// A request word is taken only in the idle state, so one request word is handled at a time;
// the search token walks the row of entry cells one cell per cycle, then come the commit and
// multiply steps, and the response word is registered once the output register is free.
// Reset (rst, synchronous): all entries invalid, total and count zero, no response.
// Key and level storage is not reset.
module bandwidth_request_aggregator import bra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  bra_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output bra_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_MUL} state_t;

  state_t           state;
  logic             start;
  logic             mode;
  logic [KEY_W-1:0] skey;
  logic [LVL_W-1:0] lvl;
  logic [SUM_W-1:0] running_total;
  logic [SUM_W-1:0] total_next;
  logic [CNT_W-1:0] requester_count;
  logic [CNT_W-1:0] count_next;
  logic [2:0]       status_next;
  logic [28:0]      res_total;
  logic [2:0]       res_status;
  logic [5:0]       res_count;
  bra_tok_t         tok [0:MAX_USERS];
  bra_tok_t         tok_end;
  bra_cmt_t         cmt;
  logic             accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  assign tok[0]  = '{act: start, hit: 1'b0, hit_level: '0, free: 1'b0};
  assign tok_end = tok[MAX_USERS];

  genvar i;
  generate
    for (i = 0; i < MAX_USERS; i++) begin : g_cell
      bra_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .skey   (skey),
        .tok_in (tok[i]),
        .tok_out(tok[i+1]),
        .cmt    (cmt)
      );
    end
  endgenerate

  always_comb begin
    cmt.en    = (state == S_SEARCH) && tok_end.act;
    cmt.hit   = tok_end.hit;
    cmt.mode  = mode;
    cmt.level = lvl;

    total_next  = running_total;
    count_next  = requester_count;
    status_next = ST_NOT_FOUND;
    if (mode == MODE_REMOVE) begin
      if (tok_end.hit) begin
        total_next  = running_total - SUM_W'(tok_end.hit_level);
        count_next  = requester_count - CNT_W'(1);
        status_next = ST_REMOVED;
      end
    end else if (tok_end.hit) begin
      total_next  = running_total - SUM_W'(tok_end.hit_level) + SUM_W'(lvl);
      status_next = ST_UPDATED;
    end else if (tok_end.free) begin
      total_next  = running_total + SUM_W'(lvl);
      count_next  = requester_count + CNT_W'(1);
      status_next = ST_ADDED;
    end else begin
      status_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      start           <= 1'b0;
      running_total   <= '0;
      requester_count <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      start <= accept;
      if (state == S_MUL && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tok_end.act) begin
            running_total   <= total_next;
            requester_count <= count_next;
            state           <= S_MUL;
          end
        end
        S_MUL: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= req.mode;
      skey <= KEY_W'(req.device_id);
      lvl  <= LVL_W'(req.level);
    end
    if (state == S_SEARCH && tok_end.act) begin
      res_status <= status_next;
      if (status_next == ST_NOT_FOUND || status_next == ST_FULL) begin
        res_total <= '0;
      end else if (64'(total_next) > 64'(TOTAL_MAX)) begin
        res_total <= TOTAL_MAX;
      end else begin
        res_total <= 29'(total_next);
      end
      res_count <= (64'(count_next) > 64'(COUNT_MAX)) ? COUNT_MAX : 6'(count_next);
    end
    if (state == S_MUL && (!rsp_valid || rsp_ready)) begin
      rsp.total_kib  <= res_total;
      rsp.total_hz   <= 37'(res_total) * 37'(HZ_SCALE);
      rsp.status     <= res_status;
      rsp.user_count <= res_count;
    end
  end

endmodule

/* rtl/bra_checker.sv */
// Port-level checks for bandwidth_request_aggregator, bound to the top level.
// Depends on bra_pkg.
module bra_checker import bra_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input bra_rsp_t rsp
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response word valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
      |-> rsp.total_kib == 29'd0 && rsp.total_hz == 37'd0)
    else $error("error response with nonzero total");

  a_hz_scale: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.total_hz == 37'(rsp.total_kib) * 37'(HZ_SCALE))
    else $error("total_hz does not match total_kib");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request word taken while busy");

endmodule

bind bandwidth_request_aggregator bra_checker u_bra_checker (.*);

/* sim/bandwidth_request_aggregator_tb.sv */
// Self-checking testbench for bandwidth_request_aggregator: directed and random request words,
// random idling on both sides, one long response hold-off, scoreboard against a local table model.
// Depends on rtl/bra_pkg.sv and rtl/bandwidth_request_aggregator.sv.
module bandwidth_request_aggregator_tb;
  import bra_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE   = 48;
  localparam int DRAIN_WAIT  = MAX_USERS + 8;

  // Mirrors the requester table and owes one response word per accepted request word.
  class bw_ledger;
    logic [KEY_W-1:0] slot_id  [MAX_USERS];
    logic [LVL_W-1:0] slot_lvl [MAX_USERS];
    bit               slot_used[MAX_USERS];
    logic [SUM_W-1:0] sum_kib = '0;
    int unsigned      held = 0;
    bra_rsp_t         owed[$];
    int               errors = 0;

    function void take_request(bra_req_t r);
      logic [KEY_W-1:0] id;
      logic [LVL_W-1:0] lvl;
      int               hit;
      int               spare;
      int               i;
      bra_rsp_t         e;
      id    = r.device_id[KEY_W-1:0];
      lvl   = r.level[LVL_W-1:0];
      hit   = -1;
      spare = -1;
      // walk downward so both end up at the lowest matching / free entry
      for (i = MAX_USERS - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_id[i] == id) hit = i;
        if (!slot_used[i]) spare = i;
      end
      if (r.mode == MODE_REMOVE) begin
        if (hit < 0) begin
          e.status = ST_NOT_FOUND;
        end else begin
          sum_kib = sum_kib - slot_lvl[hit];
          slot_used[hit] = 1'b0;
          held--;
          e.status = ST_REMOVED;
        end
      end else if (hit >= 0) begin
        sum_kib = sum_kib - slot_lvl[hit] + lvl;
        slot_lvl[hit] = lvl;
        e.status = ST_UPDATED;
      end else if (spare < 0) begin
        e.status = ST_FULL;
      end else begin
        slot_id[spare]   = id;
        slot_lvl[spare]  = lvl;
        slot_used[spare] = 1'b1;
        sum_kib = sum_kib + lvl;
        held++;
        e.status = ST_ADDED;
      end
      if (e.status == ST_NOT_FOUND || e.status == ST_FULL) e.total_kib = '0;
      else if (sum_kib > TOTAL_MAX) e.total_kib = TOTAL_MAX;
      else e.total_kib = 29'(sum_kib);
      e.total_hz   = 37'(e.total_kib) * 37'(HZ_SCALE);
      e.user_count = (held > COUNT_MAX) ? COUNT_MAX : 6'(held);
      owed.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void match_response(bra_rsp_t got);
      bra_rsp_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("response word with nothing outstanding: %h", got);
        return;
      end
      want = owed.pop_front();
      compare_field("total_kib", 64'(want.total_kib), 64'(got.total_kib));
      compare_field("total_hz", 64'(want.total_hz), 64'(got.total_hz));
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("user_count", 64'(want.user_count), 64'(got.user_count));
    endfunction

    function void close_out();
      if (owed.size() != 0) begin
        errors += owed.size();
        $display("%0d response words never arrived", owed.size());
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bra_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  bra_rsp_t rsp;

  bw_ledger board = new;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_asks = 0;
  int          stall_served = 0;
  int          hold_left = 0;
  int          quiet = 0;
  logic [15:0] key_pool[POOL_SIZE];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bandwidth_request_aggregator dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Response side: check, then pick next ready (long hold-off on request).
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.match_response(rsp);
    if (stall_asks != stall_served) begin
      hold_left = HOLD_CYCLES;
      stall_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("bandwidth_request_aggregator_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Valid stays up after a handshake unless the next word idles first.
  task automatic send_word(bra_req_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.take_request(w);
  endtask

  function automatic bra_req_t random_word(int add_pct, bit heavy);
    bra_req_t w;
    int       roll;
    w.mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_REMOVE;
    // mostly a recurring key set so entries get hit; the rest is unknown noise
    w.device_id = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : 16'($urandom);
    roll = $urandom_range(0, 7);
    if (heavy && roll != 0) w.level = '1;
    else if (roll == 0) w.level = '0;
    else if (roll == 1) w.level = '1;
    else w.level = 24'($urandom);
    return w;
  endfunction

  // Each burst is picked at random to fill, churn or drain the table.
  task automatic run_random(int count);
    int left;
    int burst;
    int add_pct;
    bit heavy;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0: begin
          add_pct = 90;
        end
        1: begin
          add_pct = 60;
        end
        default: begin
          add_pct = 25;
        end
      endcase
      heavy = ($urandom_range(0, 3) == 0);
      while (burst > 0 && left > 0) begin
        send_word(random_word(add_pct, heavy));
        burst--;
        left--;
      end
    end
  endtask

  task automatic run_directed();
    send_word('{MODE_REMOVE, 16'h1234, 24'h000000});  // remove from empty table
    send_word('{MODE_ADD, 16'h0000, 24'h000000});
    send_word('{MODE_ADD, 16'hFFFF, 24'hFFFFFF});
    send_word('{MODE_ADD, 16'h5A5A, 24'h123456});
    send_word('{MODE_ADD, 16'h0000, 24'hFFFFFF});     // replace level
    send_word('{MODE_ADD, 16'hFFFF, 24'h000000});
    send_word('{MODE_REMOVE, 16'h5A5A, 24'hFFFFFF});  // level ignored on remove
    send_word('{MODE_REMOVE, 16'h5A5A, 24'h000000});  // already gone
    send_word('{MODE_ADD, 16'hA5A5, 24'hABCDEF});     // reuses the freed entry
    send_word('{MODE_ADD, 16'h0001, 24'h000001});
    send_word('{MODE_REMOVE, 16'hFFFF, 24'h000000});
    send_word('{MODE_REMOVE, 16'h0000, 24'h000000});
    send_word('{MODE_REMOVE, 16'hA5A5, 24'h000000});
    send_word('{MODE_REMOVE, 16'h0001, 24'h000000});  // table empty again
    send_word('{MODE_REMOVE, 16'hFFFE, 24'h000000});
  endtask

  initial begin
    int k;
    for (k = 0; k < POOL_SIZE; k++) key_pool[k] = 16'($urandom);
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 59;
    run_directed();
    run_random(170);

    send_idle_pct = 59;
    recv_idle_pct = 38;
    run_random(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asks++;
    run_random(170);

    req_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("bandwidth_request_aggregator_tb: PASS");
    end else begin
      $display("bandwidth_request_aggregator_tb: FAIL");
    end
    $finish;
  end

endmodule

/* bandwidth_request_aggregator.f */
rtl/bra_pkg.sv
rtl/bra_cell.sv
rtl/bandwidth_request_aggregator.sv
rtl/bra_checker.sv
sim/bandwidth_request_aggregator_tb.sv
